### hw/rtl/dle_pkg.sv
`default_nettype none

package dle_pkg;

   // Default label length bound and the label separator
   localparam int MAX_LABEL_DEF = 62;
   localparam logic [7:0] DOT_CHAR = 8'h2E;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEN,
      ST_DATA,
      ST_ZERO
   } state_type;

   // Controls broadcast to every cell of the label chain
   typedef struct packed {
      logic load;   // write the incoming character at the cell matching the count
      logic shift;  // every cell takes its right neighbor's byte
   } cell_ctl_type;

endpackage

`default_nettype wire

### hw/rtl/dle_cell.sv
`default_nettype none

module dle_cell
   import dle_pkg::*;
#(
   parameter int IDX = 0,
   parameter int CW  = 6
) (
   input  wire logic          clock,
   input  wire cell_ctl_type  ctl,
   input  wire logic [CW-1:0] count,
   input  wire logic [7:0]    load_char,
   input  wire logic [7:0]    right_byte,
   output logic      [7:0]    data_out
);

   logic [7:0] data_ff;
   logic [7:0] data_in;

   // Load at own slot, or move one place toward the head while draining
   always_comb begin
      data_in = data_ff;
      if (ctl.load && (count == CW'(IDX))) begin
         data_in = load_char;
      end else if (ctl.shift) begin
         data_in = right_byte;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

### hw/rtl/dle_ctrl.sv
`default_nettype none

module dle_ctrl
   import dle_pkg::*;
#(
   parameter int MAX_LABEL = MAX_LABEL_DEF,
   parameter int CW        = 6
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [7:0]    req_name_char,
   input  wire logic          req_end_of_name,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic      [7:0]    rsp_out_byte,
   output logic               rsp_name_done,
   output logic               rsp_label_overflow,
   input  wire logic [7:0]    head_byte,
   output logic      [CW-1:0] count,
   output cell_ctl_type       ctl
);

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          end_ff, end_in;

   logic req_acc, rsp_acc, is_dot, full;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;
   assign is_dot  = (req_name_char == DOT_CHAR);
   assign full    = (count_ff == CW'(MAX_LABEL));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (is_dot) begin
                  state_in = (req_end_of_name && (count_ff == '0)) ? ST_ZERO : ST_LEN;
               end else if (req_end_of_name) begin
                  state_in = ST_LEN;
               end
            end
         end
         ST_LEN: begin
            if (rsp_acc) begin
               if (count_ff != '0) begin
                  state_in = ST_DATA;
               end else begin
                  state_in = end_ff ? ST_ZERO : ST_IDLE;
               end
            end
         end
         ST_DATA: begin
            if (rsp_acc && (count_ff == CW'(1))) begin
               state_in = end_ff ? ST_ZERO : ST_IDLE;
            end
         end
         ST_ZERO: begin
            if (rsp_acc) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_stall          = 1'b1;
      rsp_valid          = 1'b0;
      rsp_out_byte       = 8'h00;
      rsp_name_done      = 1'b0;
      rsp_label_overflow = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_LEN: begin
            rsp_valid    = 1'b1;
            rsp_out_byte = 8'(count_ff);
         end
         ST_DATA: begin
            rsp_valid    = 1'b1;
            rsp_out_byte = head_byte;
         end
         ST_ZERO: begin
            rsp_valid          = 1'b1;
            rsp_name_done      = 1'b1;
            rsp_label_overflow = ovf_ff;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Chain controls
   assign ctl.load  = req_acc && !is_dot && !full;
   assign ctl.shift = (state_ff == ST_DATA) && rsp_acc;

   // Count, overflow flag and end-of-name latch
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      end_in   = end_ff;
      if (req_acc) begin
         end_in = req_end_of_name;
         if (!is_dot && full) begin
            ovf_in = 1'b1;
         end
      end
      if (ctl.load) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.shift) begin
         count_in = count_ff - CW'(1);
      end
      if ((state_ff == ST_ZERO) && rsp_acc) begin
         ovf_in   = 1'b0;
         end_in   = 1'b0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         end_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         end_ff   <= end_in;
      end
   end

   assign count = count_ff;

endmodule

`default_nettype wire

### hw/rtl/dns_label_encoder.sv
// The length byte of a label appears the cycle after the dot or end of name closing it is taken.
// Characters are buffered in the cell chain while idle; a label of n bytes then drains as its
// length byte and its n bytes out of the cell chain (one byte per cycle while the output is not
// stalled), followed by the terminating zero at end of name; input stalls while a label drains.
// Reset (synchronous, active high) clears the sequencer, label count and overflow flag;
// the cell chain itself is not reset.
`default_nettype none

module dns_label_encoder
   import dle_pkg::*;
#(
   parameter int MAX_LABEL = MAX_LABEL_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_name_char,
   input  wire logic       req_end_of_name,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [7:0] rsp_out_byte,
   output logic            rsp_name_done,
   output logic            rsp_label_overflow
);

   localparam int CW = $clog2(MAX_LABEL + 1);

   cell_ctl_type  ctl;
   logic [CW-1:0] count;
   logic [7:0]    cell_q [MAX_LABEL+1];

   // Sequencer
   dle_ctrl #(
      .MAX_LABEL (MAX_LABEL),
      .CW        (CW)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_name_char      (req_name_char),
      .req_end_of_name    (req_end_of_name),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_name_done      (rsp_name_done),
      .rsp_label_overflow (rsp_label_overflow),
      .head_byte          (cell_q[0]),
      .count              (count),
      .ctl                (ctl)
   );

   // Label chain: cell 0 is the head, bytes move toward it while draining
   assign cell_q[MAX_LABEL] = 8'h00;

   for (genvar i = 0; i < MAX_LABEL; i++) begin : g_cell
      dle_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count),
         .load_char  (req_name_char),
         .right_byte (cell_q[i+1]),
         .data_out   (cell_q[i])
      );
   end

endmodule

`default_nettype wire

### hw/rtl/dle_chk.sv
`default_nettype none

module dle_chk (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_name_done,
   input wire logic       rsp_label_overflow
);

   // Terminating byte of a name is always zero
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_name_done) |-> (rsp_out_byte == 8'h00))
      else $error("name_done on nonzero byte");

   // Overflow is only reported on the terminating byte
   a_ovf_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_label_overflow) |-> rsp_name_done)
      else $error("label_overflow outside final byte");

   // Input is taken only while no output transaction is pending
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall == rsp_valid)
      else $error("input stall does not track output busy");

   // A stalled output transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_byte)
                                    && $stable(rsp_name_done)))
      else $error("stalled output transaction changed");

endmodule

bind dns_label_encoder dle_chk u_chk (.*);

`default_nettype wire
